// ===== design/artu_pkg.sv =====
// ----------------------------------------------------------------------------
// artu_pkg
// Opcodes, byte helpers and S-box tables for the AES round transform unit.
// ----------------------------------------------------------------------------
`default_nettype none
package artu_pkg;

    typedef enum logic [2:0] {
        OP_SUB        = 3'd0,
        OP_INVSUB     = 3'd1,
        OP_SHIFT      = 3'd2,
        OP_INVSHIFT   = 3'd3,
        OP_MIX        = 3'd4,
        OP_INVMIX     = 3'd5,
        OP_ADDKEY     = 3'd6,
        OP_PASS       = 3'd7
    } op_t;

    typedef logic [7:0] byte_t;
    typedef byte_t [15:0] state_t;

    localparam logic [3:0] ROWS_FWD [16] = '{
        4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
        4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11};
    localparam logic [3:0] ROWS_INV [16] = '{
        4'd0, 4'd13, 4'd10, 4'd7, 4'd4, 4'd1, 4'd14, 4'd11,
        4'd8, 4'd5, 4'd2, 4'd15, 4'd12, 4'd9, 4'd6, 4'd3};

    localparam byte_t FWD_BOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16};

    localparam byte_t INV_BOX [256] = '{
        8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
        8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
        8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
        8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
        8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
        8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
        8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
        8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
        8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
        8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
        8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
        8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
        8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
        8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
        8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
        8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
        8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
        8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
        8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
        8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
        8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
        8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
        8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
        8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
        8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
        8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
        8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
        8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
        8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
        8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
        8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
        8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d};

    function automatic byte_t xt(input byte_t a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the state sits at bits 127-8i
    function automatic state_t unpack(input logic [63:0] hi, input logic [63:0] lo);
        state_t s;
        for (int i = 0; i < 8; i++)
        begin
            s[i]     = hi[63 - 8*i -: 8];
            s[8 + i] = lo[63 - 8*i -: 8];
        end
        unpack = s;
    endfunction

    function automatic logic [63:0] pack_half(input state_t s, input logic base);
        logic [63:0] v;
        for (int i = 0; i < 8; i++)
            v[63 - 8*i -: 8] = s[{base, 3'(i)}];
        pack_half = v;
    endfunction

endpackage
`default_nettype wire

// ===== design/artu_if.sv =====
// ----------------------------------------------------------------------------
// artu_in_if / artu_out_if
// Valid/ready channels for operand items and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface artu_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [63:0] state_upper;
    logic [63:0] state_lower;
    logic [63:0] key_upper;
    logic [63:0] key_lower;
    modport source (output valid, opcode, state_upper, state_lower, key_upper, key_lower,
                    input ready);
    modport sink (input valid, opcode, state_upper, state_lower, key_upper, key_lower,
                  output ready);
endinterface

interface artu_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_upper;
    logic [63:0] result_lower;
    modport source (output valid, result_upper, result_lower, input ready);
    modport sink (input valid, result_upper, result_lower, output ready);
endinterface
`default_nettype wire

// ===== design/aes_round_transform_unit.sv =====
// ----------------------------------------------------------------------------
// aes_round_transform_unit
// One AES state transform per item, selected by opcode, three-stage pipeline.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless the output stalls; all stages advance together when the output stage is free.
// Stage 1 registers operands, stage 2 does S-box lookups / row shifts / key add,
// stage 3 does the column mix network and holds the result.
// Reset clears the valid bits only.
`default_nettype none
module aes_round_transform_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    artu_in_if.sink   in_ch,
    artu_out_if.source out_ch
);
    import artu_pkg::*;

    logic   v1_reg, v2_reg, v3_reg;
    op_t    op1_reg, op2_reg;
    state_t s1_reg, k1_reg, s2_reg, s3_reg;
    state_t s2_next, s3_next, mixed;
    logic   advance;

    assign advance     = !v3_reg || out_ch.ready;
    assign in_ch.ready = advance;

    always_comb
    begin
        s2_next = s1_reg;
        for (int i = 0; i < 16; i++)
        begin
            case (op1_reg)
                OP_SUB:      s2_next[i] = FWD_BOX[s1_reg[i]];
                OP_INVSUB:   s2_next[i] = INV_BOX[s1_reg[i]];
                OP_SHIFT:    s2_next[i] = s1_reg[ROWS_FWD[i]];
                OP_INVSHIFT: s2_next[i] = s1_reg[ROWS_INV[i]];
                OP_ADDKEY:   s2_next[i] = s1_reg[i] ^ k1_reg[i];
                default:     s2_next[i] = s1_reg[i];
            endcase
        end
    end

    artu_mix u_mix (
        .s   (s2_reg),
        .inv (op2_reg == OP_INVMIX),
        .r   (mixed)
    );

    assign s3_next = (op2_reg == OP_MIX || op2_reg == OP_INVMIX) ? mixed : s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op1_reg <= op_t'(in_ch.opcode);
            s1_reg  <= unpack(in_ch.state_upper, in_ch.state_lower);
            k1_reg  <= unpack(in_ch.key_upper, in_ch.key_lower);
            op2_reg <= op1_reg;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
        end
    end

    assign out_ch.valid        = v3_reg;
    assign out_ch.result_upper = pack_half(s3_reg, 1'b0);
    assign out_ch.result_lower = pack_half(s3_reg, 1'b1);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !out_ch.ready |=> v3_reg && $stable(s3_reg))
        else $error("result dropped while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready == (!v3_reg || out_ch.ready))
        else $error("input ready out of step with output stage");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        advance && v2_reg |=> v3_reg)
        else $error("item lost between stages");
endmodule
`default_nettype wire

// ===== design/artu_mix.sv =====
// ----------------------------------------------------------------------------
// artu_mix
// Column mixing (forward and inverse) for one state; pure XOR network.
// ----------------------------------------------------------------------------
`default_nettype none
module artu_mix (
    input  artu_pkg::state_t s,
    input  logic             inv,
    output artu_pkg::state_t r
);
    import artu_pkg::*;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            byte_t t;
            byte_t t9;
            t  = s[4*c] ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3];
            t9 = xt(xt(xt(t))) ^ t;
            for (int i = 0; i < 4; i++)
            begin
                if (inv)
                    r[4*c+i] = s[4*c+i] ^ t9
                             ^ xt(xt(s[4*c+i] ^ s[4*c+((i+2)%4)]))
                             ^ xt(s[4*c+i] ^ s[4*c+((i+1)%4)]);
                else
                    r[4*c+i] = t ^ s[4*c+i] ^ xt(s[4*c+i] ^ s[4*c+((i+1)%4)]);
            end
        end
    end
endmodule
`default_nettype wire
